// ----- rtl/mwfs_pkg.sv -----
// Package for the memory write frame serializer.
// Holds the frame item type, byte constants and group codes. No dependencies.
package mwfs_pkg;

    localparam int unsigned ADDR_W       = 26;
    localparam int unsigned ADDR_WORD_W  = 29;
    localparam int unsigned WORD_W       = 32;
    localparam int unsigned DEF_QUEUE_DEPTH = 2;

    localparam logic [7:0] MARK_BYTE    = 8'hEF;
    localparam logic [7:0] ADDR_TRAIL   = 8'hFC;
    localparam logic [7:0] DATA_TRAIL   = 8'hFE;
    localparam logic [7:0] CLOSE_FIRST  = 8'h01;
    localparam logic [7:0] CLOSE_SECOND = 8'hEB;

    // Group codes: four address bytes, tag, eight data bytes, close
    localparam logic [3:0] GRP_ADDR_B3  = 4'd0;
    localparam logic [3:0] GRP_ADDR_B2  = 4'd1;
    localparam logic [3:0] GRP_ADDR_B1  = 4'd2;
    localparam logic [3:0] GRP_ADDR_B0  = 4'd3;
    localparam logic [3:0] GRP_TAG      = 4'd4;
    localparam logic [3:0] GRP_LEFT_B3  = 4'd5;
    localparam logic [3:0] GRP_LEFT_B2  = 4'd6;
    localparam logic [3:0] GRP_LEFT_B1  = 4'd7;
    localparam logic [3:0] GRP_LEFT_B0  = 4'd8;
    localparam logic [3:0] GRP_RIGHT_B3 = 4'd9;
    localparam logic [3:0] GRP_RIGHT_B2 = 4'd10;
    localparam logic [3:0] GRP_RIGHT_B1 = 4'd11;
    localparam logic [3:0] GRP_RIGHT_B0 = 4'd12;
    localparam logic [3:0] GRP_CLOSE    = 4'd13;

    typedef enum logic [1:0] {
        PH_LEAD,
        PH_MARK,
        PH_TRAIL
    } t_phase;

    typedef enum logic {
        BK_IDLE,
        BK_SEND
    } t_back_state;

    typedef struct packed {
        logic [ADDR_WORD_W-1:0] addr_word;
        logic                   left_par;
        logic                   right_par;
        logic [WORD_W-1:0]      left_word;
        logic [WORD_W-1:0]      right_word;
    } t_frame;

endpackage

// ----- rtl/memory_write_frame_serializer.sv -----
// Channel   Valid        Ready         Payload
// in        i_in_valid   o_in_ready    i_address, i_left_word, i_right_word
// out       o_out_valid  i_out_ready   o_out_byte, o_group_start, o_last
//
// Each accepted write becomes a frame of 41 bytes, one byte per cycle while
// the output is taken; the byte sequencer in the back end sets that figure.
// A write reaching an idle back end passes the queue and the frame register;
// its first byte is then registered in the output register. Frames queued
// behind it follow with no gap. Up to QUEUE_DEPTH writes wait in the queue
// while the output stalls. Reset is synchronous, active low.
// Top level: front end, frame queue and back end. Depends on mwfs_pkg and
// the mwfs_front, mwfs_queue and mwfs_back modules.
module memory_write_frame_serializer
    import mwfs_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [ADDR_W-1:0] i_address,
    input  logic [WORD_W-1:0] i_left_word,
    input  logic [WORD_W-1:0] i_right_word,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [7:0]        o_out_byte,
    output logic              o_group_start,
    output logic              o_last
);

    t_frame w_front_frame;
    t_frame w_q_data;
    logic   w_q_ready;
    logic   w_q_valid;
    logic   w_q_pop;
    logic   w_push;

    assign o_in_ready = w_q_ready;
    assign w_push     = i_in_valid && w_q_ready;

    mwfs_front u_front (
        .i_address    (i_address),
        .i_left_word  (i_left_word),
        .i_right_word (i_right_word),
        .o_frame      (w_front_frame)
    );

    mwfs_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_front_frame),
        .o_ready (w_q_ready),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_data)
    );

    mwfs_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (w_q_valid),
        .i_q_data      (w_q_data),
        .o_q_pop       (w_q_pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_byte    (o_out_byte),
        .o_group_start (o_group_start),
        .o_last        (o_last)
    );

`ifndef SYNTHESIS
    // The byte after a frame's last one opens a new group
    a_last_then_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_last |=> !o_out_valid || o_group_start)
        else $error("byte after frame end does not start a group");

    // Pop only from a non-empty queue
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> w_q_valid)
        else $error("queue popped while empty");

    // Output is empty right after reset
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");
`endif

endmodule

// ----- rtl/mwfs_front.sv -----
// Front end: builds the address word with tag and parity bits and the data
// parities for one accepted write. Depends on mwfs_pkg.
module mwfs_front
    import mwfs_pkg::*;
(
    input  logic [ADDR_W-1:0] i_address,
    input  logic [WORD_W-1:0] i_left_word,
    input  logic [WORD_W-1:0] i_right_word,
    output t_frame            o_frame
);

    logic w_low_par;
    logic w_high_par;

    // Low parity covers bits 0-9 and the tag bit 26, which is always set
    assign w_low_par  = ~(^i_address[9:0]);
    assign w_high_par = ^i_address[22:10];

    always_comb begin
        o_frame.addr_word  = {w_high_par, w_low_par, 1'b1, i_address};
        o_frame.left_par   = ^i_left_word;
        o_frame.right_par  = ^i_right_word;
        o_frame.left_word  = i_left_word;
        o_frame.right_word = i_right_word;
    end

endmodule

// ----- rtl/mwfs_queue.sv -----
// Short frame queue between front and back ends.
// Depth must be a power of two, at least 2. Depends on mwfs_pkg.
module mwfs_queue
    import mwfs_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_frame i_data,
    output logic   o_ready,
    input  logic   i_pop,
    output logic   o_valid,
    output t_frame o_data
);

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_frame             r_entry [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;

    assign o_ready = (r_count != CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_entry[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ----- rtl/mwfs_back.sv -----
// Back end: walks one frame group by group and drives the inverted bytes
// through an output register. Depends on mwfs_pkg.
module mwfs_back
    import mwfs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_frame     i_q_data,
    output logic       o_q_pop,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_group_start,
    output logic       o_last
);

    t_back_state r_state, n_state;
    t_phase      r_phase, n_phase;
    logic [3:0]  r_group, n_group;
    t_frame      r_cur;
    logic        r_out_valid, n_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_group_start;
    logic        r_last;

    logic        w_advance;
    logic        w_frame_end;
    logic        w_load;
    logic [7:0]  w_lead;
    logic [7:0]  w_byte;

    assign o_out_valid   = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_group_start = r_group_start;
    assign o_last        = r_last;

    // Leading byte of the current group
    always_comb begin
        case (r_group)
            GRP_ADDR_B3:  w_lead = {3'b000, r_cur.addr_word[28:24]};
            GRP_ADDR_B2:  w_lead = r_cur.addr_word[23:16];
            GRP_ADDR_B1:  w_lead = r_cur.addr_word[15:8];
            GRP_ADDR_B0:  w_lead = r_cur.addr_word[7:0];
            GRP_TAG:      w_lead = {1'b0, r_cur.left_par, r_cur.right_par, 5'b00000};
            GRP_LEFT_B3:  w_lead = r_cur.left_word[31:24];
            GRP_LEFT_B2:  w_lead = r_cur.left_word[23:16];
            GRP_LEFT_B1:  w_lead = r_cur.left_word[15:8];
            GRP_LEFT_B0:  w_lead = r_cur.left_word[7:0];
            GRP_RIGHT_B3: w_lead = r_cur.right_word[31:24];
            GRP_RIGHT_B2: w_lead = r_cur.right_word[23:16];
            GRP_RIGHT_B1: w_lead = r_cur.right_word[15:8];
            GRP_RIGHT_B0: w_lead = r_cur.right_word[7:0];
            GRP_CLOSE:    w_lead = CLOSE_FIRST;
            default:      w_lead = CLOSE_FIRST;
        endcase
    end

    always_comb begin
        case (r_phase)
            PH_LEAD:  w_byte = w_lead;
            PH_MARK:  w_byte = (r_group == GRP_CLOSE) ? CLOSE_SECOND : MARK_BYTE;
            PH_TRAIL: w_byte = (r_group <= GRP_ADDR_B0) ? ADDR_TRAIL : DATA_TRAIL;
            default:  w_byte = MARK_BYTE;
        endcase
    end

    assign w_advance   = (r_state == BK_SEND) && (!r_out_valid || i_out_ready);
    assign w_frame_end = (r_group == GRP_CLOSE) && (r_phase == PH_MARK);
    assign w_load      = i_q_valid && ((r_state == BK_IDLE) || (w_advance && w_frame_end));
    assign o_q_pop     = w_load;

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_group     = r_group;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            BK_IDLE: begin
                if (i_q_valid) begin
                    n_state = BK_SEND;
                    n_phase = PH_LEAD;
                    n_group = GRP_ADDR_B3;
                end
            end
            BK_SEND: begin
                if (w_advance) begin
                    n_out_valid = 1'b1;
                    if (w_frame_end) begin
                        n_phase = PH_LEAD;
                        n_group = GRP_ADDR_B3;
                        n_state = i_q_valid ? BK_SEND : BK_IDLE;
                    end else begin
                        case (r_phase)
                            PH_LEAD:  n_phase = PH_MARK;
                            PH_MARK:  n_phase = PH_TRAIL;
                            PH_TRAIL: begin
                                n_phase = PH_LEAD;
                                n_group = r_group + 4'd1;
                            end
                            default:  n_phase = PH_LEAD;
                        endcase
                    end
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_phase     <= PH_LEAD;
            r_group     <= GRP_ADDR_B3;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_group     <= n_group;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_cur <= i_q_data;
        end
        if (w_advance) begin
            r_out_byte    <= ~w_byte;
            r_group_start <= (r_phase == PH_LEAD);
            r_last        <= w_frame_end;
        end
    end

endmodule
